// ===== sv/stb_pkg.sv =====
// shared types, constants and byte classifiers for the s-expression tokenizer
package stb_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int VAL_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int ERR_W     = 2;
    localparam int NSLOT     = 4;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        K_OPEN  = 3'd0,
        K_CLOSE = 3'd1,
        K_ABYTE = 3'd2,
        K_AEND  = 3'd3,
        K_INT   = 3'd4,
        K_SBYTE = 3'd5,
        K_SEND  = 3'd6,
        K_ERR   = 3'd7
    } t_kind;

    localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] E_ESCAPE = 2'd1;
    localparam logic [ERR_W-1:0] E_BYTE   = 2'd2;
    localparam logic [ERR_W-1:0] E_DEEP   = 2'd3;

    localparam logic [BYTE_W-1:0] C_TAB    = 8'd9;
    localparam logic [BYTE_W-1:0] C_LF     = 8'd10;
    localparam logic [BYTE_W-1:0] C_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] C_SPACE  = 8'd32;
    localparam logic [BYTE_W-1:0] C_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] C_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] C_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] C_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] C_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] C_LPAR   = 8'h28;
    localparam logic [BYTE_W-1:0] C_RPAR   = 8'h29;
    localparam logic [BYTE_W-1:0] C_LBRK   = 8'h5B;
    localparam logic [BYTE_W-1:0] C_RBRK   = 8'h5D;
    localparam logic [BYTE_W-1:0] C_LBRC   = 8'h7B;
    localparam logic [BYTE_W-1:0] C_RBRC   = 8'h7D;
    localparam logic [BYTE_W-1:0] C_LOW_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] C_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] C_LOW_T  = 8'h74;

    // one result token, the byte is zero for kinds that carry none
    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [ERR_W-1:0]  err;
        logic [BYTE_W-1:0] byt;
    } t_tok;

    // work for the back end: explicit tokens in order, then a run of closers
    typedef struct packed {
        t_tok [NSLOT-1:0]   tok;
        logic [VAL_W-1:0]   num;
        logic [DEPTH_W-1:0] closes;
        logic               fin_close;
    } t_cmd;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == C_TAB) || (c == C_LF) || (c == C_CR) || (c == C_SPACE);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic is_atom_byte(input logic [BYTE_W-1:0] c);
        logic sym;
        unique case (c)
            8'h5F, 8'h24, 8'h23, 8'h3F, 8'h2E, 8'h40, 8'h2B, 8'h2D, 8'h21, 8'h7E,
            8'h2A, 8'h2F, 8'h25, 8'h3C, 8'h3E, 8'h26, 8'h5E, 8'h7C, 8'h3D: sym = 1'b1;
            default: sym = 1'b0;
        endcase
        return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || sym;
    endfunction

    function automatic logic is_opener(input logic [BYTE_W-1:0] c);
        return (c == C_LPAR) || (c == C_LBRK) || (c == C_LBRC);
    endfunction

    function automatic logic is_closer(input logic [BYTE_W-1:0] c);
        return (c == C_RPAR) || (c == C_RBRK) || (c == C_RBRC);
    endfunction

    function automatic t_tok mk_tok(input t_kind k, input logic [ERR_W-1:0] e,
                                    input logic [BYTE_W-1:0] b);
        t_tok t;
        t.vld  = 1'b1;
        t.kind = k;
        t.err  = e;
        t.byt  = b;
        return t;
    endfunction

endpackage

// ===== sv/stb_front.sv =====
// front end: lexer state, byte classification and work packets for the queue
module stb_front
    import stb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    typedef enum logic [5:0] {
        M_START   = 6'b000001,
        M_BETWEEN = 6'b000010,
        M_COMMENT = 6'b000100,
        M_ATOM    = 6'b001000,
        M_STRING  = 6'b010000,
        M_ESCAPE  = 6'b100000
    } t_mode;

    t_mode              r_mode, n_mode, w_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_digits, n_digits;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic               r_fin, n_fin;
    logic               w_btw;
    logic               w_acc;
    t_cmd               w_cmd;

    assign w_acc = i_valid && o_ready;
    assign o_ready = !i_q_full;

    always_comb begin
        n_mode   = r_mode;
        n_depth  = r_depth;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_fin    = r_fin;
        w_cmd    = '0;
        w_cmd.num = r_acc;
        w_btw    = 1'b0;
        w_mode   = (r_mode == M_START) ? M_BETWEEN : r_mode;
        if (!r_fin) begin
            if (r_mode == M_START) begin
                w_cmd.tok[0] = mk_tok(K_OPEN, E_NONE, '0);
            end
            n_mode = w_mode;
            unique case (w_mode)
                M_ESCAPE: begin
                    n_mode = M_STRING;
                    if (i_byte == C_BSLASH || i_byte == C_QUOTE) begin
                        w_cmd.tok[2] = mk_tok(K_SBYTE, E_NONE, i_byte);
                    end else if (i_byte == C_LOW_N) begin
                        w_cmd.tok[2] = mk_tok(K_SBYTE, E_NONE, C_LF);
                    end else if (i_byte == C_LOW_R) begin
                        w_cmd.tok[2] = mk_tok(K_SBYTE, E_NONE, C_CR);
                    end else if (i_byte == C_LOW_T) begin
                        w_cmd.tok[2] = mk_tok(K_SBYTE, E_NONE, C_TAB);
                    end else begin
                        w_cmd.tok[2] = mk_tok(K_ERR, E_ESCAPE, '0);
                        n_fin = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_byte == C_QUOTE) begin
                        n_mode = M_BETWEEN;
                        w_cmd.tok[2] = mk_tok(K_SEND, E_NONE, '0);
                    end else if (i_byte == C_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        w_cmd.tok[2] = mk_tok(K_SBYTE, E_NONE, i_byte);
                    end
                end
                M_COMMENT: begin
                    if (i_byte == C_LF) begin
                        n_mode = M_BETWEEN;
                    end
                end
                M_ATOM: begin
                    if (is_atom_byte(i_byte)) begin
                        if (is_digit(i_byte)) begin
                            n_acc = (r_acc << 3) + (r_acc << 1)
                                  + VAL_W'(i_byte - C_ZERO);
                        end else begin
                            n_digits = 1'b0;
                        end
                        w_cmd.tok[2] = mk_tok(K_ABYTE, E_NONE, i_byte);
                    end else begin
                        w_cmd.tok[1] = mk_tok(r_digits ? K_INT : K_AEND, E_NONE, '0);
                        n_mode = M_BETWEEN;
                        w_btw  = 1'b1;
                    end
                end
                default: begin
                    w_btw = 1'b1;
                end
            endcase

            if (w_btw) begin
                if (is_ws(i_byte)) begin
                    n_mode = M_BETWEEN;
                end else if (i_byte == C_SEMI) begin
                    n_mode = M_COMMENT;
                end else if (is_opener(i_byte)) begin
                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        w_cmd.tok[2] = mk_tok(K_ERR, E_DEEP, '0);
                        n_fin = 1'b1;
                    end else begin
                        n_depth = r_depth + 1'b1;
                        w_cmd.tok[2] = mk_tok(K_OPEN, E_NONE, '0);
                    end
                end else if (is_closer(i_byte)) begin
                    if (r_depth == '0) begin
                        n_fin = 1'b1;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                    w_cmd.tok[2] = mk_tok(K_CLOSE, E_NONE, '0);
                end else if (i_byte == C_QUOTE) begin
                    n_mode = M_STRING;
                end else if (is_atom_byte(i_byte)) begin
                    n_mode   = M_ATOM;
                    n_digits = is_digit(i_byte);
                    n_acc    = is_digit(i_byte) ? VAL_W'(i_byte - C_ZERO) : '0;
                    w_cmd.tok[2] = mk_tok(K_ABYTE, E_NONE, i_byte);
                end else begin
                    w_cmd.tok[2] = mk_tok(K_ERR, E_BYTE, '0);
                    n_fin = 1'b1;
                end
            end

            // end of text: finish the open token, then unwind every list; a pending escape gives an error instead
            if (i_last && !n_fin) begin
                if (n_mode == M_ESCAPE) begin
                    w_cmd.tok[3] = mk_tok(K_ERR, E_ESCAPE, '0);
                end else begin
                    if (n_mode == M_ATOM) begin
                        w_cmd.tok[3] = mk_tok(n_digits ? K_INT : K_AEND, E_NONE, '0);
                        w_cmd.num    = n_acc;
                    end else if (n_mode == M_STRING) begin
                        w_cmd.tok[3] = mk_tok(K_SEND, E_NONE, '0);
                    end
                    w_cmd.closes    = n_depth;
                    w_cmd.fin_close = 1'b1;
                end
            end
        end

        if (i_last) begin
            n_mode   = M_START;
            n_depth  = '0;
            n_digits = 1'b1;
            n_acc    = '0;
            n_fin    = 1'b0;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_push = w_acc && (w_cmd.tok[0].vld || w_cmd.tok[1].vld || w_cmd.tok[2].vld
                              || w_cmd.tok[3].vld || w_cmd.fin_close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_START;
            r_depth  <= '0;
            r_digits <= 1'b1;
            r_acc    <= '0;
            r_fin    <= 1'b0;
        end else if (w_acc) begin
            r_mode   <= n_mode;
            r_depth  <= n_depth;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_fin    <= n_fin;
        end
    end

endmodule

// ===== sv/stb_queue.sv =====
// small fifo of work packets between front and back end
module stb_queue
    import stb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_full   = (r_cnt == QCNT_W'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;
    assign o_cmd    = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// ===== sv/stb_back.sv =====
// back end: expands work packets into single tokens on the output register
module stb_back
    import stb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nempty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [2:0]         o_kind,
    output logic [VAL_W-1:0]   o_value,
    output logic [ERR_W-1:0]   o_err,
    output logic               o_last
);

    logic               r_busy;
    t_cmd               r_cmd;
    t_cmd               w_rem;
    t_tok               w_tok;
    logic [VAL_W-1:0]   w_val;
    logic               w_emit;
    logic               w_is_last;
    logic               w_load;
    logic               r_ovld;
    t_kind              r_kind;
    logic [VAL_W-1:0]   r_val;
    logic [ERR_W-1:0]   r_err;
    logic               r_last;

    // pick the oldest pending token, then the closers
    always_comb begin
        w_rem = r_cmd;
        w_tok = mk_tok(K_CLOSE, E_NONE, '0);
        priority if (r_cmd.tok[0].vld) begin
            w_tok = r_cmd.tok[0];
            w_rem.tok[0].vld = 1'b0;
        end else if (r_cmd.tok[1].vld) begin
            w_tok = r_cmd.tok[1];
            w_rem.tok[1].vld = 1'b0;
        end else if (r_cmd.tok[2].vld) begin
            w_tok = r_cmd.tok[2];
            w_rem.tok[2].vld = 1'b0;
        end else if (r_cmd.tok[3].vld) begin
            w_tok = r_cmd.tok[3];
            w_rem.tok[3].vld = 1'b0;
        end else if (r_cmd.closes != '0) begin
            w_rem.closes = r_cmd.closes - 1'b1;
        end else begin
            w_rem.fin_close = 1'b0;
        end
    end

    assign w_is_last = !(w_rem.tok[0].vld || w_rem.tok[1].vld || w_rem.tok[2].vld
                         || w_rem.tok[3].vld) && (w_rem.closes == '0) && !w_rem.fin_close;
    assign w_val  = (w_tok.kind == K_INT) ? r_cmd.num : VAL_W'(w_tok.byt);
    assign w_emit = r_busy && (!r_ovld || i_ready);
    assign w_load = !r_busy || (w_emit && w_is_last);
    assign o_pop  = w_load && i_q_nempty;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end else if (w_emit) begin
            r_cmd <= w_rem;
        end
        if (w_emit) begin
            r_kind <= w_tok.kind;
            r_val  <= w_val;
            r_err  <= w_tok.err;
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= i_q_nempty;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovld;
    assign o_kind  = r_kind;
    assign o_value = r_val;
    assign o_err   = r_err;
    assign o_last  = r_last;

endmodule

// ===== sv/sexpr_byte_tokenizer_core.sv =====
// top level of the streaming s-expression tokenizer
// an item's tokens pass the queue, the packet register and then the output register
// throughput: one byte accepted per cycle while the 4-packet queue has room
// the token expander sends one token per cycle while the output is taken; an item can carry
// up to 19 tokens (end of text with 16 open lists), and sending them is what backs up the input
// reset: synchronous active-low i_rst_n clears lexer state, queue and output valid
module sexpr_byte_tokenizer_core
    import stb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input byte channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_end_of_text,
    // token channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_token_kind,
    output logic [VAL_W-1:0]   o_token_value,
    output logic [ERR_W-1:0]   o_error_code,
    output logic               o_last_of_run
);

    // front to queue
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    // queue to back
    logic w_q_nempty;
    logic w_pop;
    t_cmd w_head_cmd;

    // front: tracks lexer mode, nesting depth and the integer accumulator,
    // turns each byte into a packet of up to four tokens plus a closer run
    stb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_byte   (i_text_byte),
        .i_last   (i_end_of_text),
        .i_q_full (w_q_full),
        .o_ready  (o_in_ready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // bytes that make no token (whitespace, comments) never enter the queue
    stb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_full   (w_q_full),
        .o_nempty (w_q_nempty),
        .o_cmd    (w_head_cmd)
    );

    // back: one token per cycle into the output register while the output is taken, marks the last one
    stb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (w_q_nempty),
        .i_cmd      (w_head_cmd),
        .o_pop      (w_pop),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_kind     (o_token_kind),
        .o_value    (o_token_value),
        .o_err      (o_error_code),
        .o_last     (o_last_of_run)
    );

    // error code travels only with error tokens
    a_err_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_token_kind == K_ERR) == (o_error_code != E_NONE)))
        else $error("error code does not match token kind");

    // only integers use the upper value bits
    a_value_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind != K_INT) |-> (o_token_value[VAL_W-1:BYTE_W] == '0))
        else $error("wide value on a non-integer token");

    // a packet is popped only when the queue holds one
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_nempty)
        else $error("pop from empty queue");

endmodule

// ===== dv/tb_sexpr_byte_tokenizer_core.sv =====
// self-checking testbench for the streaming s-expression tokenizer core
`timescale 1ns / 100ps

module tb_sexpr_byte_tokenizer_core;
    import stb_pkg::*;

    // one expected token
    typedef struct {
        t_kind            kind;
        logic [VAL_W-1:0] value;
        logic [ERR_W-1:0] err;
        logic             last;
    } t_exp;

    // one directed byte; n < 0 leaves the tokens to the lexer model
    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              eot;
        int                n;
        t_kind             k0;
        logic [VAL_W-1:0]  v0;
        logic [ERR_W-1:0]  e0;
        t_kind             k1;
        logic [VAL_W-1:0]  v1;
        logic [ERR_W-1:0]  e1;
    } t_row;

    // lexer modes of the model
    typedef enum logic [2:0] {
        LX_START, LX_GAP, LX_NOTE, LX_WORD, LX_STR, LX_ESC
    } t_lex_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [BYTE_W-1:0]  i_text_byte = '0;
    logic               i_end_of_text = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_token_kind;
    logic [VAL_W-1:0]   o_token_value;
    logic [ERR_W-1:0]   o_error_code;
    logic               o_last_of_run;

    // lexer model state
    t_lex_mode          lx_mode;
    int unsigned        lx_depth;
    logic               lx_digits;
    logic [VAL_W-1:0]   lx_acc;
    logic               lx_done;

    t_exp               run_toks[$];     // tokens of the byte being modeled
    t_exp               token_fifo[$];   // tokens still owed by the block
    logic [BYTE_W-1:0]  text_q[$];       // random text under construction
    string              sym_set = "_$#?.@+-!~*/%<>&^|=";
    int unsigned        fail_cnt = 0;
    int unsigned        sent = 0;
    bit                 quiet = 1'b0;    // no idling on either side while set
    t_row               plan[25];

    sexpr_byte_tokenizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // byte classes
    // ---------------------------------------------------------------
    function automatic bit blank(input logic [BYTE_W-1:0] c);
        return c == C_TAB || c == C_LF || c == C_CR || c == C_SPACE;
    endfunction

    function automatic bit numeral(input logic [BYTE_W-1:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic bit word_byte(input logic [BYTE_W-1:0] c);
        bit hit;
        hit = numeral(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        for (int i = 0; i < sym_set.len(); i++)
            if (sym_set[i] == c) hit = 1'b1;
        return hit;
    endfunction

    // ---------------------------------------------------------------
    // lexer model
    // ---------------------------------------------------------------
    function void emit(input t_kind k, input logic [VAL_W-1:0] v, input logic [ERR_W-1:0] e);
        t_exp t;
        t.kind  = k;
        t.value = v;
        t.err   = e;
        t.last  = 1'b0;
        run_toks.push_back(t);
    endfunction

    function void clear_lexer();
        lx_mode   = LX_START;
        lx_depth  = 0;
        lx_digits = 1'b1;
        lx_acc    = '0;
        lx_done   = 1'b0;
    endfunction

    function void abort_parse(input logic [ERR_W-1:0] code);
        lx_done = 1'b1;
        emit(K_ERR, '0, code);
    endfunction

    function void end_word();
        if (lx_digits)
            emit(K_INT, lx_acc, E_NONE);
        else
            emit(K_AEND, '0, E_NONE);
        lx_mode = LX_GAP;
    endfunction

    // byte seen between tokens
    function void lex_gap(input logic [BYTE_W-1:0] c);
        if (blank(c)) begin
        end else if (c == C_SEMI) begin
            lx_mode = LX_NOTE;
        end else if (c == C_LPAR || c == C_LBRK || c == C_LBRC) begin
            if (lx_depth >= MAX_DEPTH) begin
                abort_parse(E_DEEP);
            end else begin
                lx_depth++;
                emit(K_OPEN, '0, E_NONE);
            end
        end else if (c == C_RPAR || c == C_RBRK || c == C_RBRC) begin
            // closer at top level ends the implicit list and the parse
            if (lx_depth == 0)
                lx_done = 1'b1;
            else
                lx_depth--;
            emit(K_CLOSE, '0, E_NONE);
        end else if (c == C_QUOTE) begin
            lx_mode = LX_STR;
        end else if (word_byte(c)) begin
            lx_mode   = LX_WORD;
            lx_digits = numeral(c);
            lx_acc    = numeral(c) ? VAL_W'(c - C_ZERO) : '0;
            emit(K_ABYTE, VAL_W'(c), E_NONE);
        end else begin
            abort_parse(E_BYTE);
        end
    endfunction

    function void lex_byte(input logic [BYTE_W-1:0] c);
        case (lx_mode)
            LX_ESC: begin
                lx_mode = LX_STR;
                if (c == C_BSLASH || c == C_QUOTE)
                    emit(K_SBYTE, VAL_W'(c), E_NONE);
                else if (c == C_LOW_N)
                    emit(K_SBYTE, VAL_W'(C_LF), E_NONE);
                else if (c == C_LOW_R)
                    emit(K_SBYTE, VAL_W'(C_CR), E_NONE);
                else if (c == C_LOW_T)
                    emit(K_SBYTE, VAL_W'(C_TAB), E_NONE);
                else
                    abort_parse(E_ESCAPE);
            end
            LX_STR: begin
                if (c == C_QUOTE) begin
                    lx_mode = LX_GAP;
                    emit(K_SEND, '0, E_NONE);
                end else if (c == C_BSLASH) begin
                    lx_mode = LX_ESC;
                end else begin
                    emit(K_SBYTE, VAL_W'(c), E_NONE);
                end
            end
            LX_NOTE: begin
                if (c == C_LF) lx_mode = LX_GAP;
            end
            LX_WORD: begin
                if (word_byte(c)) begin
                    if (numeral(c))
                        lx_acc = lx_acc * 64'd10 + VAL_W'(c - C_ZERO);
                    else
                        lx_digits = 1'b0;
                    emit(K_ABYTE, VAL_W'(c), E_NONE);
                end else begin
                    // terminator ends the atom, then is lexed on its own
                    end_word();
                    lex_gap(c);
                end
            end
            default: begin
                lx_mode = LX_GAP;
                lex_gap(c);
            end
        endcase
    endfunction

    // end of text: flush atom or string, then unwind every open list; a pending escape aborts instead
    function void close_text();
        if (lx_mode == LX_ESC) begin
            abort_parse(E_ESCAPE);
        end else begin
            if (lx_mode == LX_WORD)
                end_word();
            else if (lx_mode == LX_STR)
                emit(K_SEND, '0, E_NONE);
            while (lx_depth > 0) begin
                lx_depth--;
                emit(K_CLOSE, '0, E_NONE);
            end
            lx_done = 1'b1;
            emit(K_CLOSE, '0, E_NONE);
        end
    endfunction

    // tokens caused by one accepted item, left in run_toks
    function void model_item(input logic [BYTE_W-1:0] c, input logic eot);
        run_toks.delete();
        if (!lx_done) begin
            if (lx_mode == LX_START) begin
                emit(K_OPEN, '0, E_NONE);
                lx_mode = LX_GAP;
            end
            lex_byte(c);
            if (eot && !lx_done) close_text();
        end
        if (eot) clear_lexer();
    endfunction

    function void owe_tokens();
        if (run_toks.size() > 0) run_toks[run_toks.size()-1].last = 1'b1;
        foreach (run_toks[i]) token_fifo.push_back(run_toks[i]);
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] c, input logic eot);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
            model_item(text_q[i], i == text_q.size() - 1);
            owe_tokens();
        end
    endtask

    // ---------------------------------------------------------------
    // random text
    // ---------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] any_word_byte();
        case ($urandom_range(2))
            0:       return BYTE_W'(C_ZERO + $urandom_range(9));
            1:       return BYTE_W'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25));
            default: return sym_set[$urandom_range(sym_set.len() - 1)];
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_opener();
        case ($urandom_range(2))
            0:       return C_LPAR;
            1:       return C_LBRK;
            default: return C_LBRC;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_closer();
        case ($urandom_range(2))
            0:       return C_RPAR;
            1:       return C_RBRK;
            default: return C_RBRC;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_escape();
        case ($urandom_range(4))
            0:       return C_BSLASH;
            1:       return C_QUOTE;
            2:       return C_LOW_N;
            3:       return C_LOW_R;
            default: return C_LOW_T;
        endcase
    endfunction

    // mostly well-formed pieces with random content; a broken piece is the last piece of the text
    function void build_text();
        int unsigned depth;
        int unsigned pieces;
        int unsigned sel;
        int unsigned len;
        logic [BYTE_W-1:0] b;
        bit broken;
        text_q.delete();
        depth  = 0;
        broken = 1'b0;
        pieces = $urandom_range(1, 10);
        for (int p = 0; p < pieces && !broken; p++) begin
            sel = $urandom_range(99);
            if (sel < 22) begin
                // decimal literal, sometimes long enough to wrap 64 bits
                len = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
                repeat (len) text_q.push_back(BYTE_W'(C_ZERO + $urandom_range(9)));
            end else if (sel < 40) begin
                len = $urandom_range(1, 6);
                repeat (len) text_q.push_back(any_word_byte());
            end else if (sel < 55) begin
                text_q.push_back(C_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    if ($urandom_range(4) == 0) begin
                        text_q.push_back(C_BSLASH);
                        text_q.push_back(pick_escape());
                    end else begin
                        do b = BYTE_W'($urandom_range(255)); while (b == C_QUOTE || b == C_BSLASH);
                        text_q.push_back(b);
                    end
                end
                if ($urandom_range(9) != 0) text_q.push_back(C_QUOTE);
                else broken = 1'b1;
            end else if (sel < 65) begin
                len = $urandom_range(1, 3);
                repeat (len) begin
                    case ($urandom_range(3))
                        0:       text_q.push_back(C_TAB);
                        1:       text_q.push_back(C_LF);
                        2:       text_q.push_back(C_CR);
                        default: text_q.push_back(C_SPACE);
                    endcase
                end
            end else if (sel < 70) begin
                text_q.push_back(C_SEMI);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    do b = BYTE_W'($urandom_range(255)); while (b == C_LF);
                    text_q.push_back(b);
                end
                text_q.push_back(C_LF);
            end else if (sel < 80) begin
                if (depth < MAX_DEPTH) begin
                    text_q.push_back(pick_opener());
                    depth++;
                end
            end else if (sel < 90) begin
                if (depth > 0) begin
                    text_q.push_back(pick_closer());
                    depth--;
                end
            end else if (sel < 93) begin
                // nest to the limit, sometimes one level past it
                len = MAX_DEPTH + $urandom_range(1) - depth;
                repeat (len) text_q.push_back(pick_opener());
                depth  = MAX_DEPTH;
                broken = 1'b1;
            end else if (sel < 96) begin
                len = $urandom_range(1, 3);
                repeat (len) text_q.push_back(BYTE_W'($urandom_range(255)));
                broken = 1'b1;
            end else if (sel < 98) begin
                // bad escape, or an escape left hanging at end of text
                text_q.push_back(C_QUOTE);
                text_q.push_back(C_BSLASH);
                if ($urandom_range(1)) text_q.push_back(BYTE_W'($urandom_range(255)));
                broken = 1'b1;
            end else begin
                // stray closer, ends the parse at top level
                text_q.push_back(pick_closer());
                broken = 1'b1;
            end
            if (!broken && $urandom_range(1)) text_q.push_back(C_SPACE);
        end
        if (broken) begin
            // trailing bytes that a finished parse must ignore
            len = $urandom_range(0, 2);
            repeat (len) text_q.push_back(BYTE_W'($urandom_range(255)));
        end else if ($urandom_range(1)) begin
            repeat (depth) text_q.push_back(pick_closer());
        end
        if (text_q.size() == 0) text_q.push_back(any_word_byte());
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        int unsigned waited;
        t_exp t;

        plan = '{
            // first byte after reset opens the implicit list too
            '{C_LPAR,   1'b0,  2, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_NINE,   1'b0,  1, K_ABYTE, 64'h39, E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_RPAR,   1'b0,  2, K_INT,   64'd9,  E_NONE,   K_CLOSE, '0, E_NONE},
            '{C_QUOTE,  1'b0,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_BSLASH, 1'b0,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_LOW_N,  1'b0,  1, K_SBYTE, 64'd10, E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_BSLASH, 1'b0,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_QUOTE,  1'b0,  1, K_SBYTE, 64'h22, E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_BSLASH, 1'b0, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_LOW_T,  1'b0, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_BSLASH, 1'b0, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            // bad escape finishes the parse
            '{8'h78,    1'b0,  1, K_ERR,   '0,     E_ESCAPE, K_OPEN,  '0, E_NONE},
            '{C_ZERO,   1'b1,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            // invalid byte right after the implicit open
            '{8'hFF,    1'b0,  2, K_OPEN,  '0,     E_NONE,   K_ERR,   '0, E_BYTE},
            '{C_SEMI,   1'b1,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_SEMI,   1'b0,  1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{8'hFF,    1'b0,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_LF,     1'b0,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_LBRC,   1'b0,  1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{8'h61,    1'b0, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            '{C_QUOTE,  1'b0, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            // escape pending at end of text: error and no closers
            '{C_BSLASH, 1'b1,  1, K_ERR,   '0,     E_ESCAPE, K_OPEN,  '0, E_NONE},
            '{C_LOW_R,  1'b1, -1, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE},
            // closer at top level ends the parse
            '{C_RPAR,   1'b0,  2, K_OPEN,  '0,     E_NONE,   K_CLOSE, '0, E_NONE},
            '{8'h78,    1'b1,  0, K_OPEN,  '0,     E_NONE,   K_OPEN,  '0, E_NONE}
        };

        clear_lexer();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk; the model runs on every row to keep its state in step
        foreach (plan[r]) begin
            send_byte(plan[r].ch, plan[r].eot);
            model_item(plan[r].ch, plan[r].eot);
            if (plan[r].n >= 0) begin
                run_toks.delete();
                if (plan[r].n > 0) emit(plan[r].k0, plan[r].v0, plan[r].e0);
                if (plan[r].n > 1) emit(plan[r].k1, plan[r].v1, plan[r].e1);
            end
            owe_tokens();
        end

        // random texts, a quarter of them with no idling at all
        sent = 0;
        while (sent < 430) begin
            quiet = ($urandom_range(3) == 0);
            build_text();
            send_text();
        end
        i_in_valid <= 1'b0;
        quiet = 1'b0;

        waited = 0;
        while (token_fifo.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        // wait on so that any surplus token shows up
        repeat (40) @(posedge i_clk);
        if (token_fifo.size() > 0) begin
            t = token_fifo[0];
            $error("%0d tokens never arrived, first kind %0d", token_fifo.size(), t.kind);
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("[sexpr_byte_tokenizer_core] OK");
        else
            $display("[sexpr_byte_tokenizer_core] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // output side: random stall before each token
    // ---------------------------------------------------------------
    initial begin
        int unsigned stall;
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
        end
    end

    // compare every accepted token with the oldest one owed
    always @(posedge i_clk) begin : check_tokens
        t_exp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (token_fifo.size() == 0) begin
                $error("unexpected token: kind %0d value %0h", o_token_kind, o_token_value);
                fail_cnt++;
            end else begin
                want = token_fifo.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    fail_cnt++;
                end
                if (o_token_value !== want.value) begin
                    $error("token_value: expected %0h, got %0h", want.value, o_token_value);
                    fail_cnt++;
                end
                if (o_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                    fail_cnt++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20000000;
        $display("[sexpr_byte_tokenizer_core] ERROR");
        $finish;
    end

endmodule
